[rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the point to segment distance core
// Holds the default coordinate width, the region codes and the stage tag.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REGION_DEGEN    = 2'd0,
    REGION_START    = 2'd1,
    REGION_INTERIOR = 2'd2,
    REGION_END      = 2'd3
  } region_t;

  typedef struct packed {
    logic    valid;
    region_t region;
  } tag_t;

endpackage

[rtl/psd_root_step.sv]
// ----------------------------------------------------------------------------
// psd_root_step: one bit of the pipelined square root of a ratio
// Decides one result bit of floor(sqrt(num / den)) by shift, add and compare.
// ----------------------------------------------------------------------------
module psd_root_step #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  psd_pkg::tag_t               tag_in,
  input  logic [4*COORD_BITS+5:0]     rem_in,
  input  logic [4*COORD_BITS+5:0]     acc_in,
  input  logic [COORD_BITS:0]         root_in,
  input  logic [2*COORD_BITS+1:0]     den_in,
  output psd_pkg::tag_t               tag_out,
  output logic [4*COORD_BITS+5:0]     rem_out,
  output logic [4*COORD_BITS+5:0]     acc_out,
  output logic [COORD_BITS:0]         root_out,
  output logic [2*COORD_BITS+1:0]     den_out
);

  localparam int RW = 4*COORD_BITS+6;
  localparam int OW = COORD_BITS+1;

  logic [RW-1:0] den_w;
  logic [RW-1:0] cand;
  logic          take;

  assign den_w = RW'(den_in);
  assign cand  = (acc_in << (BIT+1)) + (den_w << (2*BIT));
  assign take  = rem_in >= cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out.valid <= tag_in.valid;
    end
    if (en) begin
      tag_out.region <= tag_in.region;
      den_out        <= den_in;
      if (take) begin
        rem_out  <= rem_in - cand;
        acc_out  <= acc_in + (den_w << BIT);
        root_out <= root_in | (OW'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        acc_out  <= acc_in;
        root_out <= root_in;
      end
    end
  end

endmodule

[rtl/point_segment_distance_core.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_core: distance from a point to a line segment
// Pipelined fixed-point distance with the nearest-region code.
// ----------------------------------------------------------------------------
// Input beats on s_*: tdata holds point_x, point_y, start_x, start_y, end_x,
// end_y, COORD_BITS each, signed. Output beats on m_*: tdata holds the
// floored distance (COORD_BITS+1 bits, same fraction bits as the inputs),
// tuser the region code (degenerate, nearest start, interior, nearest end).
// The pipeline has five stages of differences, products, sums, region
// select and squaring, then one stage per result bit of the square root.
// One beat enters every cycle unless the stall below holds every stage.
// Every stage holds while the last stage has a beat that m_tready refuses,
// so s_tready follows m_tready whenever the output register is full.
// Reset clears the valid bits of all stages; data registers are not reset.
// Distance is the exact value floor(sqrt(num/den)), with den = 1 at the
// ends and |AB|^2 in the interior.
// ----------------------------------------------------------------------------
module point_segment_distance_core #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // point_x, point_y, start_x, start_y, end_x, end_y from bit 0 up
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // distance from bit 0 up
  output logic [((COORD_BITS+8)/8)*8-1:0]   m_tdata,
  // region
  output logic [1:0] m_tuser
);

  localparam int N   = COORD_BITS;
  localparam int OW  = ((N+8)/8)*8;
  localparam int RW  = 4*N+6;
  localparam int DW  = 2*N+2;
  localparam int NST = N+1;

  logic en;

  // stage 1: differences
  logic                 v1;
  logic signed [N:0]    abx, aby, apx, apy, bpx, bpy;
  logic signed [N-1:0]  px, py, ax, ay, bx, by;

  assign px = s_tdata[N-1:0];
  assign py = s_tdata[2*N-1:N];
  assign ax = s_tdata[3*N-1:2*N];
  assign ay = s_tdata[4*N-1:3*N];
  assign bx = s_tdata[5*N-1:4*N];
  assign by = s_tdata[6*N-1:5*N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx <= {bx[N-1], bx} - {ax[N-1], ax};
      aby <= {by[N-1], by} - {ay[N-1], ay};
      apx <= {px[N-1], px} - {ax[N-1], ax};
      apy <= {py[N-1], py} - {ay[N-1], ay};
      bpx <= {px[N-1], px} - {bx[N-1], bx};
      bpy <= {py[N-1], py} - {by[N-1], by};
    end
  end

  // stage 2: products
  logic                  v2;
  logic signed [DW-1:0]  m_abxx, m_abyy, m_dx, m_dy, m_cx, m_cy;
  logic signed [DW-1:0]  m_apxx, m_apyy, m_bpxx, m_bpyy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_abxx <= abx * abx;
      m_abyy <= aby * aby;
      m_dx   <= apx * abx;
      m_dy   <= apy * aby;
      m_cx   <= apx * aby;
      m_cy   <= apy * abx;
      m_apxx <= apx * apx;
      m_apyy <= apy * apy;
      m_bpxx <= bpx * bpx;
      m_bpyy <= bpy * bpy;
    end
  end

  // stage 3: sums
  logic                 v3;
  logic signed [DW:0]   dot, cross_prod, ab2, pa2, pb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab2        <= {m_abxx[DW-1], m_abxx} + {m_abyy[DW-1], m_abyy};
      dot        <= {m_dx[DW-1], m_dx} + {m_dy[DW-1], m_dy};
      cross_prod <= {m_cx[DW-1], m_cx} - {m_cy[DW-1], m_cy};
      pa2        <= {m_apxx[DW-1], m_apxx} + {m_apyy[DW-1], m_apyy};
      pb2        <= {m_bpxx[DW-1], m_bpxx} + {m_bpyy[DW-1], m_bpyy};
    end
  end

  // stage 4: region select
  psd_pkg::tag_t   tag4;
  psd_pkg::region_t region_next;
  logic [DW-1:0]   mag4, mag_next;
  logic [DW-1:0]   den4, den_next;
  logic [DW:0]     cross_abs;

  assign cross_abs = cross_prod[DW] ? (DW+1)'(-cross_prod) : (DW+1)'(cross_prod);

  always_comb begin
    mag_next = '0;
    den_next = DW'(1);
    if (ab2 == '0) begin
      region_next = psd_pkg::REGION_DEGEN;
    end else if (dot >= ab2) begin
      region_next = psd_pkg::REGION_END;
      mag_next    = pb2[DW-1:0];
    end else if (dot <= 0) begin
      region_next = psd_pkg::REGION_START;
      mag_next    = pa2[DW-1:0];
    end else begin
      region_next = psd_pkg::REGION_INTERIOR;
      mag_next    = cross_abs[DW-1:0];
      den_next    = ab2[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4.valid <= 1'b0;
    end else if (en) begin
      tag4.valid <= v3;
    end
    if (en) begin
      tag4.region <= region_next;
      mag4        <= mag_next;
      den4        <= den_next;
    end
  end

  // stage 5: square the cross product in the interior, pass other magnitudes through
  psd_pkg::tag_t  tag5;
  logic [RW-1:0]  num5;
  logic [DW-1:0]  den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5.valid <= 1'b0;
    end else if (en) begin
      tag5.valid <= tag4.valid;
    end
    if (en) begin
      tag5.region <= tag4.region;
      den5        <= den4;
      if (tag4.region == psd_pkg::REGION_INTERIOR) begin
        num5 <= RW'(mag4) * RW'(mag4);
      end else begin
        num5 <= RW'(mag4);
      end
    end
  end

  // root stages, most significant bit first
  psd_pkg::tag_t tag_s  [NST+1];
  logic [RW-1:0] rem_s  [NST+1];
  logic [RW-1:0] acc_s  [NST+1];
  logic [N:0]    root_s [NST+1];
  logic [DW-1:0] den_s  [NST+1];

  assign tag_s[0]  = tag5;
  assign rem_s[0]  = num5;
  assign acc_s[0]  = '0;
  assign root_s[0] = '0;
  assign den_s[0]  = den5;

  for (genvar k = 0; k < NST; k++) begin : g_root
    psd_root_step #(
      .COORD_BITS(COORD_BITS),
      .BIT       (N - k)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tag_in  (tag_s[k]),
      .rem_in  (rem_s[k]),
      .acc_in  (acc_s[k]),
      .root_in (root_s[k]),
      .den_in  (den_s[k]),
      .tag_out (tag_s[k+1]),
      .rem_out (rem_s[k+1]),
      .acc_out (acc_s[k+1]),
      .root_out(root_s[k+1]),
      .den_out (den_s[k+1])
    );
  end

  assign en       = !tag_s[NST].valid || m_tready;
  assign s_tready = en;
  assign m_tvalid = tag_s[NST].valid;
  assign m_tdata  = OW'(root_s[NST]);
  assign m_tuser  = tag_s[NST].region;

endmodule
